FILE: hdl/serial_angle_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// Serial angle frame decoder assertion macros
// Property macros for implication checks on the decoder clock and reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_ANGLE_FRAME_DECODER_DEFINES_SVH
`define SERIAL_ANGLE_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH
`define SAFD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("safd check failed");
`define SAFD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("safd check failed");
`else
`define SAFD_ASSERT_IMP(name, ante, cons)
`define SAFD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: hdl/safd_pkg.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder package
// Frame positions, checksum and angle scaling constants, and control types.
// ----------------------------------------------------------------------------
package safd_pkg;

  localparam logic [3:0] IDX_HEADER     = 4'd0;
  localparam logic [3:0] IDX_SIGN       = 4'd1;
  localparam logic [3:0] IDX_DEGREES    = 4'd2;
  localparam logic [3:0] IDX_HUNDREDTHS = 4'd3;
  localparam logic [3:0] IDX_PRODUCT    = 4'd4;
  localparam logic [3:0] IDX_REMAINDER  = 4'd5;
  localparam logic [3:0] IDX_SUM_LAST   = 4'd6;
  localparam logic [3:0] IDX_LOW_SUM    = 4'd7;
  localparam logic [3:0] IDX_MOD_SUM    = 4'd8;
  localparam logic [3:0] IDX_TRAILER    = 4'd9;

  localparam logic [7:0] HEADER_BYTE = 8'h73;
  localparam logic [7:0] NEG_CODE    = 8'h01;

  // The sum of six bytes fits 11 bits, so a reciprocal scaled by 2^16 gives an exact mod-17.
  localparam logic [11:0] MOD17_RECIP = 12'd3856;

  // Angle scale 3141592 / 18000000 reduced to 392699 / 2250000.
  localparam logic [18:0] ANG_MUL = 19'd392699;
  localparam logic [21:0] ANG_DIV = 22'd2250000;
  localparam int unsigned ANG_RECIP_SHIFT = 36;
  localparam logic [63:0] ANG_RECIP_FULL =
    ((64'd392699 << ANG_RECIP_SHIFT) + 64'd2249999) / 64'd2250000;
  localparam logic [33:0] ANG_RECIP = ANG_RECIP_FULL[33:0];

  localparam logic signed [17:0] ANG_SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] ANG_SAT_MIN = -18'sd32768;

  typedef struct packed {
    logic at_end;
    logic load_mag;
    logic load_prod;
    logic load_rem;
    logic finish;
    logic good;
    logic init;
  } safd_ctl_t;

endpackage

FILE: hdl/safd_byte_if.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder byte channel
// Valid/ready channel carrying a command bit and a received byte.
// ----------------------------------------------------------------------------
interface safd_byte_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: hdl/safd_result_if.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder result channel
// Valid/ready channel carrying the decoded angle and the frame status.
// ----------------------------------------------------------------------------
interface safd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_mrad;
  logic               frame_good;

  modport source (output valid, output angle_mrad, output frame_good, input ready);
  modport sink (input valid, input angle_mrad, input frame_good, output ready);
endinterface

FILE: hdl/safd_frame.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder frame tracker
// Byte position, header and checksum checks, and angle stage enables.
// ----------------------------------------------------------------------------
module safd_frame import safd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  output logic [7:0] degrees_o,
  output logic       negative_o,
  output safd_ctl_t  ctl_o
);

  logic [3:0]  idx_q, idx_d, idx_eff;
  logic [10:0] sum_q, sum_d;
  logic        hdr_q, hdr_d;
  logic        neg_q, neg_d;
  logic [7:0]  deg_q, deg_d;
  logic        match_q, match_d;
  logic [4:0]  mod17_q, mod17_d;
  logic        data_acc;
  logic [22:0] m17_prod;
  logic [6:0]  m17_quot;
  logic [10:0] m17_back;
  logic [10:0] m17_rem;

  assign data_acc = accept_i && !cmd_i;
  assign idx_eff  = (idx_q > IDX_TRAILER) ? IDX_HEADER : idx_q;

  assign m17_prod = sum_q * MOD17_RECIP;
  assign m17_quot = m17_prod[22:16];
  assign m17_back = {m17_quot, 4'b0000} + {4'b0000, m17_quot};
  assign m17_rem  = sum_q - m17_back;

  always_comb begin
    idx_d   = idx_q;
    sum_d   = sum_q;
    hdr_d   = hdr_q;
    neg_d   = neg_q;
    deg_d   = deg_q;
    match_d = match_q;
    mod17_d = mod17_q;
    if (data_acc) begin
      idx_d = (idx_eff == IDX_TRAILER) ? IDX_HEADER : idx_eff + 4'd1;
      case (idx_eff)
        IDX_HEADER: begin
          hdr_d = (data_byte_i == HEADER_BYTE);
          sum_d = '0;
        end
        IDX_SIGN: begin
          sum_d = sum_q + {3'b000, data_byte_i};
          neg_d = (data_byte_i == NEG_CODE);
        end
        IDX_DEGREES: begin
          sum_d = sum_q + {3'b000, data_byte_i};
          deg_d = data_byte_i;
        end
        IDX_HUNDREDTHS, IDX_PRODUCT, IDX_REMAINDER, IDX_SUM_LAST: begin
          sum_d = sum_q + {3'b000, data_byte_i};
        end
        IDX_LOW_SUM: begin
          match_d = (sum_q[7:0] == data_byte_i);
          mod17_d = m17_rem[4:0];
        end
        IDX_MOD_SUM: begin
          if ({3'b000, mod17_q} != data_byte_i) begin
            match_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IDX_HEADER;
      sum_q   <= '0;
      hdr_q   <= 1'b0;
      neg_q   <= 1'b0;
      deg_q   <= '0;
      match_q <= 1'b0;
      mod17_q <= '0;
    end else begin
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      hdr_q   <= hdr_d;
      neg_q   <= neg_d;
      deg_q   <= deg_d;
      match_q <= match_d;
      mod17_q <= mod17_d;
    end
  end

  assign degrees_o  = deg_q;
  assign negative_o = neg_q;

  always_comb begin
    ctl_o.at_end    = (idx_eff == IDX_TRAILER);
    ctl_o.load_mag  = data_acc && (idx_eff == IDX_HUNDREDTHS);
    ctl_o.load_prod = data_acc && (idx_eff == IDX_PRODUCT);
    ctl_o.load_rem  = data_acc && (idx_eff == IDX_REMAINDER);
    ctl_o.finish    = data_acc && (idx_eff == IDX_TRAILER);
    ctl_o.good      = hdr_q && match_q;
    ctl_o.init      = accept_i && cmd_i;
  end

endmodule

FILE: hdl/safd_angle.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder angle datapath
// Scales degrees to milliradians in steps spread over the frame bytes.
// ----------------------------------------------------------------------------
module safd_angle import safd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  safd_ctl_t          ctl_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         degrees_i,
  input  logic               negative_i,
  output logic signed [15:0] result_o
);

  logic [14:0]        mag_q, mag_d;
  logic [12:0]        quot_q, quot_d;
  logic [33:0]        prod_q, prod_d;
  logic               nz_q, nz_d;
  logic signed [15:0] last_q, last_d;
  logic signed [15:0] off_q, off_d;
  logic [48:0]        recip_prod;
  logic [34:0]        back_prod;
  logic signed [17:0] quot_s, floor_s, diff_s, trunc_s;
  logic signed [15:0] sat_angle;

  assign recip_prod = mag_q * ANG_RECIP;
  assign back_prod  = quot_q * ANG_DIV;

  assign mag_d  = ctl_i.load_mag ?
                  15'({7'b0000000, degrees_i} * 15'd100) + {7'b0000000, data_byte_i} : mag_q;
  assign quot_d = ctl_i.load_prod ? recip_prod[48:36] : quot_q;
  assign prod_d = ctl_i.load_prod ? 34'(mag_q * ANG_MUL) : prod_q;
  assign nz_d   = ctl_i.load_rem ? (back_prod[33:0] != prod_q) : nz_q;

  // Floor of the signed scaled value, then truncation toward zero after the offset.
  always_comb begin
    quot_s  = $signed({5'b00000, quot_q});
    floor_s = negative_i ? (nz_q ? -quot_s - 18'sd1 : -quot_s) : quot_s;
    diff_s  = floor_s - $signed({{2{off_q[15]}}, off_q});
    trunc_s = (diff_s[17] && nz_q) ? diff_s + 18'sd1 : diff_s;
    if (trunc_s > ANG_SAT_MAX) begin
      sat_angle = 16'sh7fff;
    end else if (trunc_s < ANG_SAT_MIN) begin
      sat_angle = -16'sh8000;
    end else begin
      sat_angle = trunc_s[15:0];
    end
  end

  assign result_o = ctl_i.good ? sat_angle : last_q;
  assign last_d   = ctl_i.finish ? result_o : last_q;
  assign off_d    = ctl_i.init ? last_q : off_q;

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    quot_q <= quot_d;
    prod_q <= prod_d;
    nz_q   <= nz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      off_q  <= '0;
    end else begin
      last_q <= last_d;
      off_q  <= off_d;
    end
  end

endmodule

FILE: hdl/serial_angle_frame_decoder.sv
// ----------------------------------------------------------------------------
// Serial angle frame decoder
// Decodes ten-byte serial frames into an angle in milliradians.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer
//  rx_i     in         one command or one received byte
//  tx_o     out        angle and frame status, once per ten bytes
//
// One transfer is taken every cycle; the result of a frame appears on tx_o
// the cycle after its last byte is taken. The scaling multiply is spread over
// bytes four and five of the frame. A transfer offered while the frame sits at
// its last byte waits while the output register holds a result tx_o has not
// yet taken. Reset clears the frame position, the angle and the offset.
`include "serial_angle_frame_decoder_defines.svh"

module serial_angle_frame_decoder import safd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  safd_byte_if.sink    rx_i,
  safd_result_if.source tx_o
);

  safd_ctl_t          ctl;
  logic               accept;
  logic [7:0]         degrees;
  logic               negative;
  logic signed [15:0] result;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_angle_q, out_angle_d;
  logic               out_good_q, out_good_d;

  assign rx_i.ready = !(out_valid_q && !tx_o.ready) || !ctl.at_end;
  assign accept     = rx_i.valid && rx_i.ready;

  safd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (rx_i.cmd),
    .data_byte_i (rx_i.data_byte),
    .degrees_o   (degrees),
    .negative_o  (negative),
    .ctl_o       (ctl)
  );

  safd_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .data_byte_i (rx_i.data_byte),
    .degrees_i   (degrees),
    .negative_i  (negative),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_angle_d = out_angle_q;
    out_good_d  = out_good_q;
    if (ctl.finish) begin
      out_valid_d = 1'b1;
      out_angle_d = result;
      out_good_d  = ctl.good;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_angle_q <= out_angle_d;
    out_good_q  <= out_good_d;
  end

  assign tx_o.valid      = out_valid_q;
  assign tx_o.angle_mrad = out_angle_q;
  assign tx_o.frame_good = out_good_q;

  `SAFD_ASSERT_NEXT(a_finish_gives_result, accept && ctl.finish, tx_o.valid)
  `SAFD_ASSERT_IMP(a_stall_only_when_full, !rx_i.ready, tx_o.valid && !tx_o.ready && ctl.at_end)
  `SAFD_ASSERT_NEXT(a_no_spurious_result, accept && !ctl.finish, !$rose(tx_o.valid))

endmodule
